### rtl/core/generational_handle_table_macros.svh
// ----------------------------------------------------------------------------
// generational_handle_table_macros.svh
// Assertion macros used by the checker file of the handle table.
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_TABLE_MACROS_SVH
`define GENERATIONAL_HANDLE_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GHT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/ght_pkg.sv
// ----------------------------------------------------------------------------
// ght_pkg
// Types, constants and helper functions of the generational handle table.
// ----------------------------------------------------------------------------
package ght_pkg;

  localparam int SLOTS    = 64;
  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W    = $clog2(SLOTS + 1);
  localparam int GEN_W    = 32;
  localparam int HANDLE_W = 2 * GEN_W;
  localparam int NODE_W   = 64;
  localparam int TAG_W    = 31;
  localparam int LIVE_W   = 7;

  // Stream payload layout.
  localparam int IN_DATA_W  = 160;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 168;
  localparam int OUT_USER_W = 2;

  typedef enum logic [1:0] {
    FN_INSERT     = 2'd0,
    FN_LOOKUP     = 2'd1,
    FN_REMOVE     = 2'd2,
    FN_REMOVE_CHK = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_STALE   = 2'd2,
    ST_NOSPACE = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } ght_cmd_t;

  typedef struct packed {
    logic [GEN_W-1:0]  gen;
    logic              dir;
    logic [TAG_W-1:0]  tag;
    logic [NODE_W-1:0] node;
  } entry_t;

  // Priority encoder: index of the lowest clear bit of the used bitmap.
  function automatic logic [SLOT_W-1:0] first_free(input logic [SLOTS-1:0] used);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        idx = SLOT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

### rtl/core/ght_ctrl.sv
// ----------------------------------------------------------------------------
// ght_ctrl
// Sequencer of the handle table: input handshake, execute step, output valid.
// ----------------------------------------------------------------------------
module ght_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output ght_pkg::ght_cmd_t  cmd
);
  import ght_pkg::*;

  state_t state_r, state_nxt;
  logic   out_vld_r, out_vld_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    out_vld_nxt = out_vld_r & ~out_tready;
    in_tready   = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        // Commit only once the output register can take the new word.
        if (!out_vld_r || out_tready) begin
          cmd.commit  = 1'b1;
          out_vld_nxt = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_vld_r;

endmodule

### rtl/core/ght_datapath.sv
// ----------------------------------------------------------------------------
// ght_datapath
// Slot bitmap, entry memory, handle check and result register.
// ----------------------------------------------------------------------------
module ght_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ght_pkg::ght_cmd_t             cmd,
  input  ght_pkg::func_t                func,
  input  logic [ght_pkg::HANDLE_W-1:0]  handle_in,
  input  logic [ght_pkg::NODE_W-1:0]    node_in,
  input  logic                          is_directory,
  input  logic [ght_pkg::TAG_W-1:0]     tag_in,
  output ght_pkg::status_t              status,
  output logic [ght_pkg::HANDLE_W-1:0]  handle_out,
  output logic [ght_pkg::NODE_W-1:0]    node_out,
  output logic [ght_pkg::TAG_W-1:0]     tag_out,
  output logic [ght_pkg::LIVE_W-1:0]    live_entries
);
  import ght_pkg::*;

  entry_t              mem [SLOTS];
  logic [SLOTS-1:0]    used_r, used_nxt;
  logic [SLOTS-1:0]    gvld_r, gvld_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;

  func_t               func_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [NODE_W-1:0]   node_r;
  logic                dir_r;
  logic [TAG_W-1:0]    tag_r;
  logic [SLOT_W-1:0]   addr_r;
  logic                full_r;
  entry_t              rd_r;

  logic [GEN_W-1:0]    lo_m1;
  logic [SLOT_W-1:0]   rd_addr;
  logic [GEN_W-1:0]    lo, hgen, cur_gen, gen_inc, gen_new;
  logic                hok;
  logic                wr_en;
  entry_t              wr_row;
  status_t             st_nxt;
  logic [HANDLE_W-1:0] h_nxt;
  logic [NODE_W-1:0]   n_nxt;
  logic [TAG_W-1:0]    t_nxt;

  // Memory address at accept time: lowest free slot for insert, else handle slot.
  assign lo_m1   = handle_in[GEN_W-1:0] - GEN_W'(1);
  assign rd_addr = (func == FN_INSERT) ? first_free(used_r) : lo_m1[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r   <= func;
      handle_r <= handle_in;
      node_r   <= node_in;
      dir_r    <= is_directory;
      tag_r    <= tag_in;
      addr_r   <= rd_addr;
      full_r   <= &used_r;
      rd_r     <= mem[rd_addr];
    end
    if (cmd.commit && wr_en) begin
      mem[addr_r] <= wr_row;
    end
  end

  // Handle check against the entry read at accept time.
  assign lo      = handle_r[GEN_W-1:0];
  assign hgen    = handle_r[HANDLE_W-1:GEN_W];
  assign cur_gen = gvld_r[addr_r] ? rd_r.gen : '0;
  assign hok     = (lo != '0) && (lo <= GEN_W'(SLOTS)) && (hgen != '0) &&
                   used_r[addr_r] && (cur_gen == hgen) && (rd_r.dir == dir_r);
  assign gen_inc = cur_gen + GEN_W'(1);
  assign gen_new = (gen_inc == '0) ? GEN_W'(1) : gen_inc;

  always_comb begin
    st_nxt   = ST_OK;
    h_nxt    = '0;
    n_nxt    = '0;
    t_nxt    = '0;
    used_nxt = used_r;
    gvld_nxt = gvld_r;
    cnt_nxt  = cnt_r;
    wr_en    = 1'b0;
    wr_row   = '{gen: gen_new, dir: dir_r, tag: tag_r, node: node_r};
    case (func_r)
      FN_INSERT: begin
        if (node_r == '0) begin
          st_nxt = ST_INVALID;
        end else if (full_r) begin
          st_nxt = ST_NOSPACE;
        end else begin
          wr_en            = 1'b1;
          used_nxt[addr_r] = 1'b1;
          gvld_nxt[addr_r] = 1'b1;
          cnt_nxt          = cnt_r + CNT_W'(1);
          h_nxt            = {gen_new, GEN_W'(addr_r) + GEN_W'(1)};
        end
      end
      FN_LOOKUP: begin
        if (!hok) begin
          st_nxt = ST_STALE;
        end else begin
          n_nxt = rd_r.node;
          t_nxt = rd_r.tag;
        end
      end
      FN_REMOVE: begin
        if (!hok) begin
          st_nxt = ST_STALE;
        end else begin
          used_nxt[addr_r] = 1'b0;
          cnt_nxt          = cnt_r - CNT_W'(1);
        end
      end
      FN_REMOVE_CHK: begin
        if (node_r == '0) begin
          st_nxt = ST_INVALID;
        end else if (!hok || (rd_r.node != node_r)) begin
          st_nxt = ST_STALE;
        end else begin
          used_nxt[addr_r] = 1'b0;
          cnt_nxt          = cnt_r - CNT_W'(1);
        end
      end
      default: begin
        st_nxt = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      gvld_r <= '0;
      cnt_r  <= '0;
    end else if (cmd.commit) begin
      used_r <= used_nxt;
      gvld_r <= gvld_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status       <= st_nxt;
      handle_out   <= h_nxt;
      node_out     <= n_nxt;
      tag_out      <= t_nxt;
      live_entries <= LIVE_W'(cnt_nxt);
    end
  end

endmodule

### rtl/core/generational_handle_table.sv
// ----------------------------------------------------------------------------
// generational_handle_table
// Handle table with per-slot generation counters (insert, lookup, remove).
// ----------------------------------------------------------------------------
// Requests come in as words on the in_ stream: in_tuser carries the operation
// and the directory flag, in_tdata the handle, node id and resource tag. Each
// request gives exactly one result word on the out_ stream: out_tuser carries
// the status, out_tdata the new handle, the looked-up node id and tag and the
// live count after the operation.
// A request runs as an accept step, which reads the entry memory (the slot
// comes from the free-slot priority encoder for an insert, or from the handle
// otherwise), and an execute step, which checks, updates the memory and
// bitmap, and loads the output register. The entry memory's single
// read-modify-write sets this, so no new word is taken until the last one
// commits and loads its result; the next word can be accepted while it waits.
// A stalled receiver holds the result in the output register; the block then
// holds the next request in its execute step and takes no further word.
// Reset clears the slot bitmap, the generation valid bits and the live count,
// so every slot reads as free with generation zero; no clearing pass is needed.
module generational_handle_table (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [1:0] func, [2] is_directory
  input  logic [ght_pkg::IN_USER_W-1:0]      in_tuser,
  // [63:0] handle_in, [127:64] node_in, [158:128] tag_in, [159] zero
  input  logic [ght_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [1:0] status
  output logic [ght_pkg::OUT_USER_W-1:0]     out_tuser,
  // [63:0] handle_out, [127:64] node_out, [158:128] tag_out,
  // [165:159] live_entries, [167:166] zero
  output logic [ght_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import ght_pkg::*;

  ght_cmd_t            cmd;
  status_t             status;
  logic [HANDLE_W-1:0] handle_out;
  logic [NODE_W-1:0]   node_out;
  logic [TAG_W-1:0]    tag_out;
  logic [LIVE_W-1:0]   live_entries;

  ght_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  ght_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .func         (func_t'(in_tuser[1:0])),
    .handle_in    (in_tdata[63:0]),
    .node_in      (in_tdata[127:64]),
    .is_directory (in_tuser[2]),
    .tag_in       (in_tdata[158:128]),
    .status       (status),
    .handle_out   (handle_out),
    .node_out     (node_out),
    .tag_out      (tag_out),
    .live_entries (live_entries)
  );

  assign out_tuser = status;
  assign out_tdata = {2'b00, live_entries, tag_out, node_out, handle_out};

endmodule

### rtl/core/ght_checker.sv
// ----------------------------------------------------------------------------
// ght_checker
// Port-level checks of the handle table, bound to the top level.
// ----------------------------------------------------------------------------
`include "generational_handle_table_macros.svh"

module ght_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [ght_pkg::OUT_USER_W-1:0]     out_tuser,
  input logic [ght_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import ght_pkg::*;

  // A stalled result word must not change.
  `GHT_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // One request at a time: the cycle after an accept is the execute step.
  `GHT_ASSERT_NXT(a_one_in_flight, clk, rst_n, in_tvalid && in_tready, !in_tready, "accepted a word during execute")

  // Failed operations return no handle, node id or tag.
  `GHT_ASSERT_IMP(a_fail_zero, clk, rst_n, out_tvalid && (out_tuser != ST_OK), out_tdata[158:0] == '0, "failed result carries data")

  // A returned handle always has a nonzero generation and slot field.
  `GHT_ASSERT_IMP(a_handle_fields, clk, rst_n, out_tvalid && (out_tdata[63:0] != '0), (out_tdata[63:32] != '0) && (out_tdata[31:0] != '0) && (out_tdata[127:64] == '0), "malformed handle")

endmodule

bind generational_handle_table ght_checker u_ght_checker (.*);
